// ----- hw/rtl/sfd_pkg.sv -----
package sfd_pkg;

    localparam int FRAME_LEN     = 25;
    localparam int POS_W         = $clog2(FRAME_LEN);
    localparam int PAYLOAD_BYTES = 22;
    localparam int BITS_W        = 8 * PAYLOAD_BYTES;
    localparam int NUM_CH        = 16;
    localparam int CH_W          = 11;
    localparam int IDX_W         = $clog2(NUM_CH);

    localparam logic [POS_W-1:0] HEADER_POS = POS_W'(0);
    localparam logic [POS_W-1:0] FLAG_POS   = POS_W'(FRAME_LEN - 2);
    localparam logic [POS_W-1:0] FOOTER_POS = POS_W'(FRAME_LEN - 1);
    localparam logic [7:0]       HEADER_BYTE = 8'h0F;
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_CH - 1);

    typedef enum logic [1:0] {
        LINK_OK       = 2'd0,
        LINK_LOST     = 2'd1,
        LINK_FAILSAFE = 2'd2
    } sfd_link_t;

    // controller -> datapath
    typedef struct packed {
        logic store_byte;   // input transfer: store byte, step position
        logic start_emit;   // footer of a good frame: rewind channel index
        logic advance;      // output transfer: move to the next channel
    } sfd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic at_footer;
        logic header_ok;
        logic last_index;
    } sfd_status_t;

endpackage

// ----- hw/rtl/sfd_ctrl.sv -----
module sfd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  sfd_pkg::sfd_status_t status,
    output sfd_pkg::sfd_cmd_t   cmd
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;
    logic   out_xfer;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd.store_byte = in_xfer;
        cmd.start_emit = 1'b0;
        cmd.advance    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && status.at_footer && status.header_ok)
                begin
                    cmd.start_emit = 1'b1;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_xfer)
                begin
                    cmd.advance = 1'b1;
                    if (status.last_index)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hw/rtl/sfd_datapath.sv -----
module sfd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfd_pkg::sfd_cmd_t             cmd,
    output sfd_pkg::sfd_status_t          status,
    input  logic [7:0]                    rx_byte,
    output logic [sfd_pkg::IDX_W-1:0]     channel_index,
    output logic [sfd_pkg::CH_W-1:0]      channel_value,
    output logic                          digital_one,
    output logic                          digital_two,
    output logic [1:0]                    link_status
);
    import sfd_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic [7:0]        header_reg;
    logic [7:0]        header_next;
    logic [7:0]        flag_reg;
    logic [7:0]        flag_next;
    // bytes 1..22 packed LSB first; drained 11 bits per emitted channel
    logic [BITS_W-1:0] bits_reg;
    logic [BITS_W-1:0] bits_next;
    sfd_link_t         link;

    always_comb
    begin
        pos_next    = pos_reg;
        index_next  = index_reg;
        header_next = header_reg;
        flag_next   = flag_reg;
        bits_next   = bits_reg;
        if (cmd.store_byte)
        begin
            pos_next = (pos_reg == FOOTER_POS) ? '0 : pos_reg + POS_W'(1);
            if (pos_reg == HEADER_POS)
            begin
                header_next = rx_byte;
            end
            if (pos_reg == FLAG_POS)
            begin
                flag_next = rx_byte;
            end
            for (int i = 0; i < PAYLOAD_BYTES; i++)
            begin
                if (pos_reg == POS_W'(i + 1))
                begin
                    bits_next[8*i +: 8] = rx_byte;
                end
            end
        end
        if (cmd.start_emit)
        begin
            index_next = '0;
        end
        if (cmd.advance)
        begin
            index_next = index_reg + IDX_W'(1);
            bits_next  = {{CH_W{1'b0}}, bits_reg[BITS_W-1:CH_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            index_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            index_reg <= index_next;
        end
    end

    always_ff @(posedge clk)
    begin
        header_reg <= header_next;
        flag_reg   <= flag_next;
        bits_reg   <= bits_next;
    end

    // failsafe wins over lost
    always_comb
    begin
        if (flag_reg[3])
        begin
            link = LINK_FAILSAFE;
        end
        else if (flag_reg[2])
        begin
            link = LINK_LOST;
        end
        else
        begin
            link = LINK_OK;
        end
    end

    assign status.at_footer  = (pos_reg == FOOTER_POS);
    assign status.header_ok  = (header_reg == HEADER_BYTE);
    assign status.last_index = (index_reg == LAST_IDX);

    assign channel_index = index_reg;
    assign channel_value = bits_reg[CH_W-1:0];
    assign digital_one   = flag_reg[0];
    assign digital_two   = flag_reg[1];
    assign link_status   = link;

endmodule

// ----- hw/rtl/sbus_frame_decoder.sv -----
// Decoder for a 25-byte, 16-channel serial receiver frame.
// Input channel: one received byte per transfer on rx_byte (in_valid/in_ready).
// Bytes are counted modulo 25; bytes 0..23 are kept, byte 24 is the footer.
// When the footer is taken and byte 0 was 0x0F, sixteen results follow on the
// output channel (out_valid/out_ready), channel_index 0..15, last_channel set
// on the sixteenth. Each carries the 11-bit channel value, the two digital
// bits and the link status from flag byte 23. A bad header gives no results.
// The first result is valid in the cycle after the footer transfer.
// Throughput: one byte per cycle while no frame is being emitted; after a
// good footer, one result per cycle while out_ready is high, with in_ready
// low until all are taken. Emission drains a 176-bit payload shift register
// by one channel per output transfer.
// Receiver stall: a result holds on the outputs until taken; input stays
// blocked until all sixteen are delivered.
// Reset: byte position returns to 0 and no output is pending; stored frame
// bytes are not cleared (they are rewritten before the next footer).
module sbus_frame_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sfd_pkg::IDX_W-1:0] channel_index,
    output logic [sfd_pkg::CH_W-1:0]  channel_value,
    output logic                      digital_one,
    output logic                      digital_two,
    output logic [1:0]                link_status,
    output logic                      last_channel
);
    import sfd_pkg::*;

    sfd_cmd_t    cmd;
    sfd_status_t status;

    sfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    sfd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx_byte),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .digital_one   (digital_one),
        .digital_two   (digital_two),
        .link_status   (link_status)
    );

    assign last_channel = status.last_index;

endmodule

// ----- hw/rtl/sfd_checker.sv -----
module sfd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sfd_pkg::IDX_W-1:0]   channel_index,
    input logic [sfd_pkg::CH_W-1:0]    channel_value,
    input logic                        digital_one,
    input logic                        digital_two,
    input logic [1:0]                  link_status,
    input logic                        last_channel
);
    import sfd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(channel_index)
            && $stable(channel_value) && $stable(link_status)
            && $stable(digital_one) && $stable(digital_two))
        else $error("stalled result changed");

    // input is blocked while a frame is emitted
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted during emission");

    // channels come out in order with no gaps
    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_channel |=>
            out_valid && channel_index == IDX_W'($past(channel_index) + IDX_W'(1)))
        else $error("channel sequence broken");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_channel |=> !out_valid && in_ready)
        else $error("emission did not end after last channel");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_channel |-> channel_index == LAST_IDX)
        else $error("last_channel on wrong index");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .digital_one   (digital_one),
    .digital_two   (digital_two),
    .link_status   (link_status),
    .last_channel  (last_channel)
);

// ----- tb/sv/sbus_frame_decoder_tb.sv -----
module sbus_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  value;
        logic             dig_one;
        logic             dig_two;
        sfd_link_t        link;
        logic             last;
    } chan_result_t;

    typedef struct {
        logic [7:0] data;
        bit         hold_until_drained;
    } rx_item_t;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

    localparam int RANDOM_BYTES = 90;
    localparam int SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] rx_byte = 8'h00;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [IDX_W-1:0] channel_index;
    logic [CH_W-1:0] channel_value;
    logic digital_one;
    logic digital_two;
    logic [1:0] link_status;
    logic last_channel;

    sbus_frame_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .digital_one   (digital_one),
        .digital_two   (digital_two),
        .link_status   (link_status),
        .last_channel  (last_channel)
    );

    always #1 clk = ~clk;

    // stimulus and expected channel results
    rx_item_t rx_queue[$];
    chan_result_t pending_channels[$];
    int stream_pos = 0;
    int sent_cnt = 0;
    int taken_cnt = 0;
    int error_cnt = 0;

    // decoder shadow state
    logic [POS_W-1:0] rx_pos = '0;
    logic [7:0] frame_bytes [0:FRAME_LEN-2];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns ERROR %s: got %0d expected %0d", $time, what, got, want);
        error_cnt++;
    endtask

    task automatic decode_rx_byte(input logic [7:0] b);
        logic [BITS_W-1:0] payload;
        logic [7:0] flags;
        chan_result_t r;
        if (rx_pos != FOOTER_POS)
        begin
            frame_bytes[rx_pos] = b;
            rx_pos = rx_pos + POS_W'(1);
        end
        else
        begin
            rx_pos = '0;
            if (frame_bytes[HEADER_POS] == HEADER_BYTE)
            begin
                for (int i = 0; i < PAYLOAD_BYTES; i++)
                    payload[8*i +: 8] = frame_bytes[i+1];
                flags = frame_bytes[FLAG_POS];
                for (int k = 0; k < NUM_CH; k++)
                begin
                    r.idx     = IDX_W'(k);
                    r.value   = payload[k*CH_W +: CH_W];
                    r.dig_one = flags[0];
                    r.dig_two = flags[1];
                    // failsafe wins over lost
                    if (flags[3])
                        r.link = LINK_FAILSAFE;
                    else if (flags[2])
                        r.link = LINK_LOST;
                    else
                        r.link = LINK_OK;
                    r.last    = (r.idx == LAST_IDX);
                    pending_channels.push_back(r);
                end
            end
        end
    endtask

    function automatic logic [7:0] rand_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        else if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_byte(input logic [7:0] b, input bit hold);
        rx_item_t it;
        it.data = b;
        it.hold_until_drained = hold;
        rx_queue.push_back(it);
        stream_pos = (stream_pos + 1) % FRAME_LEN;
    endtask

    task automatic queue_frame(input logic [7:0] header, input fill_t fill,
                               input logic [7:0] flags, input logic [7:0] footer,
                               input bit hold);
        queue_byte(header, hold);
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            case (fill)
                FILL_ZERO: queue_byte(8'h00, 1'b0);
                FILL_ONES: queue_byte(8'hFF, 1'b0);
                default:   queue_byte(rand_byte(), 1'b0);
            endcase
        end
        queue_byte(flags, 1'b0);
        queue_byte(footer, 1'b0);
    endtask

    function automatic logic [7:0] bad_header();
        logic [7:0] h;
        h = 8'($urandom_range(0, 254));
        if (h >= HEADER_BYTE)
            h = h + 8'd1;
        return h;
    endfunction

    task automatic build_stimulus();
        int start_len;
        int sel;
        int n;
        // max channels, both digitals, failsafe with lost also set
        queue_frame(HEADER_BYTE, FILL_ONES, 8'hFF, 8'h00, 1'b1);
        // zero channels, lost only, upper flag bits set and ignored
        queue_frame(HEADER_BYTE, FILL_ZERO, 8'hF4, 8'hFF, 1'b1);
        // bad header: footer must produce nothing
        queue_frame(8'hF0, FILL_RANDOM, 8'h0B, 8'h5A, 1'b0);
        start_len = rx_queue.size();
        while (rx_queue.size() < start_len + RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 6)
            begin
                while (stream_pos != 0)
                    queue_byte(rand_byte(), 1'b0);
                queue_frame(HEADER_BYTE, FILL_RANDOM, rand_byte(), rand_byte(),
                            $urandom_range(0, 9) == 0);
            end
            else if (sel == 7)
            begin
                while (stream_pos != 0)
                    queue_byte(rand_byte(), 1'b0);
                queue_frame(bad_header(), FILL_RANDOM, rand_byte(), rand_byte(), 1'b0);
            end
            else if (sel == 8)
            begin
                // line noise, knocks the framing out of step
                n = $urandom_range(1, 30);
                repeat (n)
                    queue_byte(($urandom_range(0, 5) == 0) ? HEADER_BYTE : rand_byte(), 1'b0);
            end
            else
            begin
                // truncated frame
                queue_byte(HEADER_BYTE, 1'b0);
                n = $urandom_range(1, 23);
                repeat (n)
                    queue_byte(rand_byte(), 1'b0);
            end
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk)
    begin : rx_driver
        rx_item_t head;
        if (rst_n && (!in_valid || taken_cnt == sent_cnt))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (rx_queue.size() == 0 ||
                     (rx_queue[0].hold_until_drained && pending_channels.size() != 0))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                head = rx_queue.pop_front();
                rx_byte  <= head.data;
                in_valid <= 1'b1;
                sent_cnt++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 10);
                    gap_left = $urandom_range(0, 8);
                end
            end
        end
    end

    // receiver: cycles through ready patterns
    logic [8:0] stall_cycle = '0;
    always @(negedge clk)
    begin
        stall_cycle = stall_cycle + 9'd1;
        case (stall_cycle[8:7])
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    out_ready <= (stall_cycle[2:0] == 3'd0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk)
    begin : channel_monitor
        chan_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_channels.size() == 0)
                begin
                    report_mismatch("unexpected result, channel_index", channel_index, -1);
                end
                else
                begin
                    want = pending_channels.pop_front();
                    if (channel_index !== want.idx)
                        report_mismatch("channel_index", channel_index, want.idx);
                    if (channel_value !== want.value)
                        report_mismatch("channel_value", channel_value, want.value);
                    if (digital_one !== want.dig_one)
                        report_mismatch("digital_one", digital_one, want.dig_one);
                    if (digital_two !== want.dig_two)
                        report_mismatch("digital_two", digital_two, want.dig_two);
                    if (link_status !== want.link)
                        report_mismatch("link_status", link_status, want.link);
                    if (last_channel !== want.last)
                        report_mismatch("last_channel", last_channel, want.last);
                end
            end
            if (in_valid && in_ready)
            begin
                decode_rx_byte(rx_byte);
                taken_cnt++;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (rx_queue.size() != 0 || taken_cnt != sent_cnt || pending_channels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_channels.size() != 0)
            report_mismatch("channels still expected", 0, pending_channels.size());
        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- sbus_frame_decoder.f -----
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_ctrl.sv
hw/rtl/sfd_datapath.sv
hw/rtl/sbus_frame_decoder.sv
hw/rtl/sfd_checker.sv
tb/sv/sbus_frame_decoder_tb.sv
